[rtl/core/sha256_pkg.sv]
// SHA-256 hasher package: payload types, round constants and round functions.
`default_nettype none

package sha256_pkg;

    typedef struct packed {
        logic [7:0] message_byte;
        logic       byte_present;
        logic       end_of_message;
    } item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } digest_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_FILL = 6'd56;

    localparam logic [31:0] INITIAL_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] ch(input logic [31:0] e, input logic [31:0] f,
                                       input logic [31:0] g);
        ch = (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] maj(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
        maj = (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

`default_nettype wire

[rtl/core/sha256_byte_stream_hasher.sv]
// SHA-256 byte stream hasher top level: block memory, hash memory and round sequencer.
//
//   channel | dir | signals                            | request
//   item    | in  | item_valid, item_ready, item       | one message byte and flags
//   digest  | out | digest_valid, digest_ready, digest | one digest word
//
// A data byte is shifted into the block word when accepted; the 64th byte of a block
// starts a compression (hash loads, 64 rounds, hash write-backs), one round per cycle.
// An end request pads one byte per cycle outside compressions (up to 72 bytes over one
// or two blocks, each compressed), then sends eight digest words via ST_READ and ST_SEND.
// Reset clears control state; the hash memory reads as the initial values until written.
// item_ready is low while padding, compressing or sending; digest stalls hold the word.
`default_nettype none

module sha256_byte_stream_hasher (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      item_valid,
    output logic                     item_ready,
    input  wire sha256_pkg::item_t   item,
    output logic                     digest_valid,
    input  wire                      digest_ready,
    output sha256_pkg::digest_t      digest
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FIN,
        ST_READ,
        ST_SEND
    } state_t;

    state_t      state_reg;
    state_t      ret_reg;
    logic [5:0]  fill_reg;
    logic [31:0] word_reg;
    logic [63:0] bit_count_reg;
    logic        pad_started_reg;
    logic        len_phase_reg;
    logic        fresh_reg;
    logic [5:0]  cnt_reg;
    logic        digest_valid_reg;
    logic [31:0] wv_reg [8];
    logic [31:0] win_reg [16];

    logic [31:0] sched_mem [16];
    logic [31:0] sched_rd_reg;
    logic [31:0] hash_mem [8];
    logic [31:0] hash_rd_reg;
    logic [2:0]  hash_raddr_reg;

    logic        item_fire;
    logic        pad_len_sel;
    logic        ins_en;
    logic [7:0]  ins_byte;
    logic [31:0] word_next;
    logic        sched_we;
    logic [3:0]  sched_raddr;
    logic [2:0]  hash_raddr;
    logic        hash_we;
    logic [2:0]  hash_waddr;
    logic [31:0] hash_rd;
    logic [31:0] hash_wdata;
    logic [31:0] wt;
    logic [31:0] t1;
    logic [31:0] t2;

    assign item_ready = (state_reg == ST_IDLE);
    assign item_fire  = item_valid && item_ready;

    assign pad_len_sel = pad_started_reg && (len_phase_reg || (fill_reg == sha256_pkg::LEN_FILL));

    always_comb
    begin
        ins_en   = 1'b0;
        ins_byte = item.message_byte;
        if (state_reg == ST_IDLE)
        begin
            ins_en = item_fire && item.byte_present;
        end
        else if (state_reg == ST_PAD)
        begin
            ins_en = 1'b1;
            if (!pad_started_reg)
                ins_byte = sha256_pkg::PAD_BYTE;
            else if (pad_len_sel)
                ins_byte = bit_count_reg[{~fill_reg[2:0], 3'b000} +: 8];
            else
                ins_byte = 8'h00;
        end
    end

    assign word_next = {word_reg[23:0], ins_byte};
    assign sched_we  = ins_en && (fill_reg[1:0] == 2'b11);

    assign sched_raddr = (state_reg == ST_ROUND) ? (cnt_reg[3:0] + 4'd1) : 4'd0;
    assign hash_raddr  = cnt_reg[2:0];
    assign hash_rd     = fresh_reg ? sha256_pkg::INITIAL_H[hash_raddr_reg] : hash_rd_reg;
    assign hash_we     = (state_reg == ST_FIN) && (cnt_reg != 6'd0);
    assign hash_waddr  = cnt_reg[2:0] - 3'd1;
    assign hash_wdata  = hash_rd + wv_reg[0];

    assign wt = (cnt_reg < 6'd16) ? sched_rd_reg
              : (sha256_pkg::ssig1(win_reg[14]) + win_reg[9] +
                 sha256_pkg::ssig0(win_reg[1]) + win_reg[0]);
    assign t1 = wv_reg[7] + sha256_pkg::bsig1(wv_reg[4]) +
                sha256_pkg::ch(wv_reg[4], wv_reg[5], wv_reg[6]) +
                sha256_pkg::ROUND_K[cnt_reg] + wt;
    assign t2 = sha256_pkg::bsig0(wv_reg[0]) + sha256_pkg::maj(wv_reg[0], wv_reg[1], wv_reg[2]);

    always_ff @(posedge clk)
    begin
        if (sched_we)
            sched_mem[fill_reg[5:2]] <= word_next;
        sched_rd_reg <= sched_mem[sched_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hash_we)
            hash_mem[hash_waddr] <= hash_wdata;
        hash_rd_reg    <= hash_mem[hash_raddr];
        hash_raddr_reg <= hash_raddr;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                win_reg[i] <= win_reg[i + 1];
            win_reg[15] <= wt;
            wv_reg[7] <= wv_reg[6];
            wv_reg[6] <= wv_reg[5];
            wv_reg[5] <= wv_reg[4];
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[3] <= wv_reg[2];
            wv_reg[2] <= wv_reg[1];
            wv_reg[1] <= wv_reg[0];
            wv_reg[0] <= t1 + t2;
        end
        else if ((state_reg == ST_LOAD || state_reg == ST_FIN) && cnt_reg != 6'd0)
        begin
            for (int i = 0; i < 7; i++)
                wv_reg[i] <= wv_reg[i + 1];
            wv_reg[7] <= hash_rd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ret_reg          <= ST_IDLE;
            fill_reg         <= 6'd0;
            word_reg         <= 32'd0;
            bit_count_reg    <= 64'd0;
            pad_started_reg  <= 1'b0;
            len_phase_reg    <= 1'b0;
            fresh_reg        <= 1'b1;
            cnt_reg          <= 6'd0;
            digest_valid_reg <= 1'b0;
        end
        else
        begin
            if (ins_en)
            begin
                fill_reg <= fill_reg + 6'd1;
                word_reg <= word_next;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    pad_started_reg <= 1'b0;
                    len_phase_reg   <= 1'b0;
                    cnt_reg         <= 6'd0;
                    if (item_fire)
                    begin
                        if (item.byte_present)
                            bit_count_reg <= bit_count_reg + 64'd8;
                        if (item.byte_present && fill_reg == 6'd63)
                        begin
                            state_reg <= ST_LOAD;
                            ret_reg   <= item.end_of_message ? ST_PAD : ST_IDLE;
                        end
                        else if (item.end_of_message)
                            state_reg <= ST_PAD;
                    end
                end
                ST_PAD:
                begin
                    pad_started_reg <= 1'b1;
                    cnt_reg         <= 6'd0;
                    if (pad_len_sel)
                        len_phase_reg <= 1'b1;
                    if (fill_reg == 6'd63)
                    begin
                        state_reg <= ST_LOAD;
                        ret_reg   <= pad_len_sel ? ST_READ : ST_PAD;
                    end
                end
                ST_LOAD:
                begin
                    if (cnt_reg == 6'd8)
                    begin
                        cnt_reg   <= 6'd0;
                        state_reg <= ST_ROUND;
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                ST_ROUND:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                        state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (cnt_reg == 6'd8)
                    begin
                        cnt_reg   <= 6'd0;
                        fresh_reg <= 1'b0;
                        state_reg <= ret_reg;
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                ST_READ:
                begin
                    digest_valid_reg <= 1'b1;
                    state_reg        <= ST_SEND;
                end
                ST_SEND:
                begin
                    if (digest_ready)
                    begin
                        digest_valid_reg <= 1'b0;
                        if (cnt_reg[2:0] == 3'd7)
                        begin
                            state_reg     <= ST_IDLE;
                            fresh_reg     <= 1'b1;
                            fill_reg      <= 6'd0;
                            bit_count_reg <= 64'd0;
                            cnt_reg       <= 6'd0;
                        end
                        else
                        begin
                            cnt_reg   <= cnt_reg + 6'd1;
                            state_reg <= ST_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign digest_valid       = digest_valid_reg;
    assign digest.digest_word = hash_rd;
    assign digest.word_number = cnt_reg[2:0];
    assign digest.last_word   = (cnt_reg[2:0] == 3'd7);

endmodule

`default_nettype wire

[rtl/core/sha256_checker.sv]
// Port checker for the SHA-256 hasher, with its bind to the top level.
`default_nettype none

module sha256_checker (
    input wire                       clk,
    input wire                       rst_n,
    input wire                       item_valid,
    input wire                       item_ready,
    input wire sha256_pkg::item_t    item,
    input wire                       digest_valid,
    input wire                       digest_ready,
    input wire sha256_pkg::digest_t  digest
);

    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(item))
        else $error("item request dropped or changed while stalled");

    a_digest_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_ready |=> digest_valid && $stable(digest))
        else $error("digest request dropped or changed while stalled");

    a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (digest.last_word == (digest.word_number == 3'd7)))
        else $error("last_word does not match word_number");

    a_no_item_during_digest: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> !item_ready)
        else $error("item taken while digest pending");

    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_ready && digest.last_word |=> item_ready && !digest_valid)
        else $error("block not idle after final digest word");

endmodule

bind sha256_byte_stream_hasher sha256_checker u_sha256_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest       (digest)
);

`default_nettype wire
